FILE: rtl/trk_pkg.sv
// Shared types and constants of the tunnelled TCP connection tracker.
package trk_pkg;

   // Frame screening values.
   localparam logic [15:0] ETH_IPV6          = 16'h86DD;
   localparam logic [7:0]  NH_ICMPV6         = 8'd58;
   localparam logic [15:0] ECHO_REQ_CODE0    = 16'h8000;
   localparam logic [15:0] HDR_OVERHEAD      = 16'd28;
   localparam logic [15:0] SERVER_PORT_RESET = 16'd60000;

   // Configuration port layout: one 32-bit register per word.
   localparam int unsigned CSR_ADDR_W         = 3;
   localparam logic        CSR_IDX_SERVER_PORT = 1'b0;

   // Flag bit positions.
   localparam int unsigned FLAG_ACK = 0;
   localparam int unsigned FLAG_SYN = 1;
   localparam int unsigned FLAG_FIN = 2;

   typedef enum logic [1:0] {
      KIND_FRAME = 2'd0,
      KIND_CHUNK = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_BAD   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_LISTEN   = 3'd0,
      PH_HSHAKE   = 3'd1,
      PH_DATA     = 3'd2,
      PH_SENDING  = 3'd3,
      PH_DATA_ACK = 3'd4,
      PH_FIN_ACK  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ACT_DROP   = 3'd0,
      ACT_SILENT = 3'd1,
      ACT_SYNACK = 3'd2,
      ACT_ACK    = 3'd3,
      ACT_DATA   = 3'd4,
      ACT_FIN    = 3'd5,
      ACT_DONE   = 3'd6
   } action_type;

   // A word after classification by the front part.
   typedef struct packed {
      kind_type     kind;
      logic         screen_ok;
      logic [15:0]  sport;
      logic [63:0]  ip_high;
      logic [63:0]  ip_low;
      logic [47:0]  mac;
      logic [31:0]  seq_num;
      logic [31:0]  ack_num;
      logic [2:0]   flags;
      logic [15:0]  length;
   } item_type;

   typedef struct packed {
      action_type   action;
      logic [31:0]  reply_seq;
      logic [31:0]  reply_ack;
      logic [15:0]  reply_length;
      phase_type    conn_phase;
   } result_type;

endpackage

FILE: rtl/trk_queue.sv
// Small first-in first-out queue used between the parts of the tracker.
module trk_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/trk_front.sv
// Front part: screens the fixed header fields of a word and packs it for the back part.
module trk_front
   import trk_pkg::*;
(
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_eth_proto,
   input  logic [7:0]  req_next_header,
   input  logic [15:0] req_icmp_type_code,
   input  logic [31:0] req_tcp_ports,
   input  logic [63:0] req_src_ip_high,
   input  logic [63:0] req_src_ip_low,
   input  logic [47:0] req_src_mac,
   input  logic [31:0] req_seq_num,
   input  logic [31:0] req_ack_num,
   input  logic [2:0]  req_tcp_flags,
   input  logic [15:0] req_length,
   input  logic [15:0] server_port,
   output item_type    item
);
   always_comb begin
      item.kind      = kind_type'(req_kind);
      // The checks that need no connection state are done here.
      item.screen_ok = (req_eth_proto == ETH_IPV6) &&
                       (req_next_header == NH_ICMPV6) &&
                       (req_icmp_type_code == ECHO_REQ_CODE0) &&
                       (req_tcp_ports[15:0] == server_port);
      item.sport     = req_tcp_ports[31:16];
      item.ip_high   = req_src_ip_high;
      item.ip_low    = req_src_ip_low;
      item.mac       = req_src_mac;
      item.seq_num   = req_seq_num;
      item.ack_num   = req_ack_num;
      item.flags     = req_tcp_flags;
      item.length    = req_length;
   end

endmodule

FILE: rtl/trk_back.sv
// Back part: holds the connection state and turns each classified word into a result.
module trk_back
   import trk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_take,
   input  logic       result_full,
   output logic       result_push,
   output result_type result
);
   phase_type   phase_ff, phase_in;
   logic [31:0] own_seq_ff, own_seq_in;
   logic [31:0] peer_seq_ff, peer_seq_in;
   logic [31:0] exp_seq_ff, exp_seq_in;
   logic [31:0] exp_ack_ff, exp_ack_in;
   logic [63:0] client_ip_high_ff, client_ip_low_ff;
   logic [47:0] client_mac_ff;
   logic [15:0] client_port_ff;
   logic        client_we;
   logic        fire;
   logic        client_match;
   logic        nums_ok;
   logic        f_ack, f_syn, f_fin;
   logic [15:0] data_len;

   assign fire        = item_valid && !result_full;
   assign item_take   = fire;
   assign result_push = fire;

   assign client_match = (item.ip_high == client_ip_high_ff) &&
                         (item.ip_low == client_ip_low_ff) &&
                         (item.mac == client_mac_ff) &&
                         (item.sport == client_port_ff);
   assign nums_ok  = (item.seq_num == exp_seq_ff) && (item.ack_num == exp_ack_ff);
   assign f_ack    = item.flags[FLAG_ACK];
   assign f_syn    = item.flags[FLAG_SYN];
   assign f_fin    = item.flags[FLAG_FIN];
   // Only payload beyond the tunnel overhead advances the peer sequence.
   assign data_len = (item.length > HDR_OVERHEAD) ? item.length - HDR_OVERHEAD : 16'd0;

   always_comb begin
      phase_in            = phase_ff;
      own_seq_in          = own_seq_ff;
      peer_seq_in         = peer_seq_ff;
      exp_seq_in          = exp_seq_ff;
      exp_ack_in          = exp_ack_ff;
      client_we           = 1'b0;
      result.action       = ACT_DROP;
      result.reply_seq    = '0;
      result.reply_ack    = '0;
      result.reply_length = '0;
      if (fire) begin
         case (item.kind)
            KIND_CHUNK: begin
               if (phase_ff == PH_SENDING) begin
                  own_seq_in          = own_seq_ff + {16'd0, item.length};
                  exp_ack_in          = own_seq_in;
                  result.action       = ACT_DATA;
                  result.reply_seq    = own_seq_ff;
                  result.reply_ack    = peer_seq_ff;
                  result.reply_length = item.length;
               end
            end
            KIND_DONE: begin
               if (phase_ff == PH_SENDING) begin
                  phase_in      = PH_DATA_ACK;
                  result.action = ACT_DONE;
               end
            end
            KIND_FRAME: begin
               if (item.screen_ok && (phase_ff == PH_LISTEN || client_match)) begin
                  if (phase_ff == PH_FIN_ACK && f_ack && f_fin && nums_ok) begin
                     own_seq_in       = own_seq_ff + 32'd1;
                     peer_seq_in      = peer_seq_ff + 32'd1;
                     exp_seq_in       = '0;
                     exp_ack_in       = '0;
                     phase_in         = PH_LISTEN;
                     result.action    = ACT_ACK;
                     result.reply_seq = own_seq_in;
                     result.reply_ack = peer_seq_in;
                  end else if (phase_ff == PH_LISTEN && f_syn) begin
                     client_we        = 1'b1;
                     peer_seq_in      = item.seq_num + 32'd1;
                     exp_seq_in       = peer_seq_in;
                     own_seq_in       = own_seq_ff + 32'd1;
                     exp_ack_in       = own_seq_in;
                     phase_in         = PH_HSHAKE;
                     result.action    = ACT_SYNACK;
                     result.reply_seq = own_seq_ff;
                     result.reply_ack = peer_seq_in;
                  end else if (phase_ff == PH_HSHAKE && f_ack && nums_ok) begin
                     phase_in      = PH_DATA;
                     result.action = ACT_SILENT;
                  end else if (phase_ff == PH_DATA && nums_ok) begin
                     peer_seq_in      = peer_seq_ff + {16'd0, data_len};
                     exp_seq_in       = peer_seq_in;
                     phase_in         = PH_SENDING;
                     result.action    = ACT_ACK;
                     result.reply_seq = own_seq_ff;
                     result.reply_ack = peer_seq_in;
                  end else if (phase_ff == PH_DATA_ACK && f_ack && nums_ok) begin
                     exp_ack_in       = own_seq_ff + 32'd1;
                     phase_in         = PH_FIN_ACK;
                     result.action    = ACT_FIN;
                     result.reply_seq = own_seq_ff;
                     result.reply_ack = peer_seq_ff;
                  end
               end
            end
            default: begin
               result.action = ACT_DROP;
            end
         endcase
      end
      result.conn_phase = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LISTEN;
         own_seq_ff  <= '0;
         peer_seq_ff <= '0;
         exp_seq_ff  <= '0;
         exp_ack_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         own_seq_ff  <= own_seq_in;
         peer_seq_ff <= peer_seq_in;
         exp_seq_ff  <= exp_seq_in;
         exp_ack_ff  <= exp_ack_in;
      end
   end

   always_ff @(posedge clock) begin
      if (client_we) begin
         client_ip_high_ff <= item.ip_high;
         client_ip_low_ff  <= item.ip_low;
         client_mac_ff     <= item.mac;
         client_port_ff    <= item.sport;
      end
   end

endmodule

FILE: rtl/tunneled_tcp_server_connection_tracker.sv
// Top level of the tunnelled TCP server connection tracker.
//
// Each word pushed on the req_ side gives exactly one result word on the rsp_ side, in order.
// The block takes one word per clock cycle sustained while rsp_pop keeps up; each word,
// and then its result, waits in a queue on the way to the rsp_ ports. The front part
// screens the fixed header fields and the back part walks the connection state, one word
// a cycle while the result queue has room; a queue of QUEUE_DEPTH words parts the two, and
// a second queue of QUEUE_DEPTH words holds results until they are popped, so req_full rises
// only when both queues have filled behind a stalled rsp_pop. The server port register lies
// at byte address 0 of the csr_ port and should be written only while no word is in flight.
module tunneled_tcp_server_connection_tracker
   import trk_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [1:0]            req_kind,
   input  logic [15:0]           req_eth_proto,
   input  logic [7:0]            req_next_header,
   input  logic [15:0]           req_icmp_type_code,
   input  logic [31:0]           req_tcp_ports,
   input  logic [63:0]           req_src_ip_high,
   input  logic [63:0]           req_src_ip_low,
   input  logic [47:0]           req_src_mac,
   input  logic [31:0]           req_seq_num,
   input  logic [31:0]           req_ack_num,
   input  logic [2:0]            req_tcp_flags,
   input  logic [15:0]           req_length,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [2:0]            rsp_action,
   output logic [31:0]           rsp_reply_seq,
   output logic [31:0]           rsp_reply_ack,
   output logic [15:0]           rsp_reply_length,
   output logic [2:0]            rsp_conn_phase,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   localparam int unsigned ITEM_W   = $bits(item_type);
   localparam int unsigned RESULT_W = $bits(result_type);

   logic [15:0] server_port_ff, server_port_in;
   logic        csr_hit;
   item_type    front_item, back_item;
   logic [ITEM_W-1:0] back_item_bits;
   logic        mid_empty, back_take;
   logic        out_full, out_push;
   result_type  back_result, out_result;
   logic [RESULT_W-1:0] out_result_bits;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_SERVER_PORT);
   assign csr_prdata = csr_hit ? {16'd0, server_port_ff} : 32'd0;

   always_comb begin
      server_port_in = server_port_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         server_port_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         server_port_ff <= SERVER_PORT_RESET;
      end else begin
         server_port_ff <= server_port_in;
      end
   end

   trk_front u_front (
      .req_kind           (req_kind),
      .req_eth_proto      (req_eth_proto),
      .req_next_header    (req_next_header),
      .req_icmp_type_code (req_icmp_type_code),
      .req_tcp_ports      (req_tcp_ports),
      .req_src_ip_high    (req_src_ip_high),
      .req_src_ip_low     (req_src_ip_low),
      .req_src_mac        (req_src_mac),
      .req_seq_num        (req_seq_num),
      .req_ack_num        (req_ack_num),
      .req_tcp_flags      (req_tcp_flags),
      .req_length         (req_length),
      .server_port        (server_port_ff),
      .item               (front_item)
   );

   trk_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_item),
      .full      (req_full),
      .pop       (back_take),
      .pop_data  (back_item_bits),
      .empty     (mid_empty)
   );

   assign back_item = item_type'(back_item_bits);

   trk_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (!mid_empty),
      .item        (back_item),
      .item_take   (back_take),
      .result_full (out_full),
      .result_push (out_push),
      .result      (back_result)
   );

   trk_queue #(
      .WIDTH (RESULT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (back_result),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_result_bits),
      .empty     (rsp_empty)
   );

   assign out_result       = result_type'(out_result_bits);
   assign rsp_action       = out_result.action;
   assign rsp_reply_seq    = out_result.reply_seq;
   assign rsp_reply_ack    = out_result.reply_ack;
   assign rsp_reply_length = out_result.reply_length;
   assign rsp_conn_phase   = out_result.conn_phase;

endmodule

FILE: rtl/trk_checker.sv
// Port-level checks of the connection tracker and their binding to the top level.
module trk_checker
   import trk_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [2:0]  rsp_action,
   input logic [31:0] rsp_reply_seq,
   input logic [31:0] rsp_reply_ack,
   input logic [15:0] rsp_reply_length,
   input logic [2:0]  rsp_conn_phase
);
   // A word that is waiting and not popped stays on the ports.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_action) && $stable(rsp_reply_seq))
      else $error("waiting result word changed before it was popped");

   // Results that send no segment carry no numbers.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_action == ACT_DROP || rsp_action == ACT_SILENT ||
                     rsp_action == ACT_DONE) |-> rsp_reply_seq == 32'd0 && rsp_reply_ack == 32'd0)
      else $error("non-sending result word carries sequence numbers");

   // Only a data segment has a payload length.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_action != ACT_DATA |-> rsp_reply_length == 16'd0)
      else $error("payload length on a result word that is not a data segment");

   // Each of the SYNACK, FIN, DATA and DONE actions leaves the connection in its own phase.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_action == ACT_SYNACK || rsp_action == ACT_FIN ||
                     rsp_action == ACT_DATA || rsp_action == ACT_DONE) |->
      (rsp_action == ACT_SYNACK && rsp_conn_phase == PH_HSHAKE) ||
      (rsp_action == ACT_FIN && rsp_conn_phase == PH_FIN_ACK) ||
      (rsp_action == ACT_DATA && rsp_conn_phase == PH_SENDING) ||
      (rsp_action == ACT_DONE && rsp_conn_phase == PH_DATA_ACK))
      else $error("result word phase does not suit its action");

   // Nothing is shown right after reset.
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown right after reset");

endmodule

bind tunneled_tcp_server_connection_tracker trk_checker u_trk_checker (.*);
